// ----- rtl/utf8_to_utf16_decoder_macros.svh -----
// utf8_to_utf16_decoder_macros.svh
// assertion macros for the utf-8 to utf-16 decoder; no dependencies
// expects signals named clock and reset in the including scope
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/u8u16_pkg.sv -----
// u8u16_pkg.sv
// constants and types for the utf-8 to utf-16 decoder
// no dependencies
package u8u16_pkg;

   // field widths
   localparam int BYTE_WIDTH      = 8;
   localparam int CODE_WIDTH      = 21;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 1;

   // result queue sizing
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // code values
   localparam logic [CODE_WIDTH-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
   localparam logic [CODE_WIDTH-1:0] HI_SURR_BASE     = 21'h00D800;
   localparam logic [CODE_WIDTH-1:0] LO_SURR_BASE     = 21'h00DC00;
   localparam logic [CODE_WIDTH-1:0] SUPP_PLANE_BASE  = 21'h010000;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UTF16_OUTPUT        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_SURROGATE_FIRST = 2'd1;

   // pending range check on the first continuation byte
   typedef enum logic [2:0] {
      CHK_NONE = 3'd0,
      CHK_E0   = 3'd1,
      CHK_ED   = 3'd2,
      CHK_F0   = 3'd3,
      CHK_F4   = 3'd4
   } check_type;

   // one queued result
   typedef struct packed {
      logic [CODE_WIDTH-1:0] code_unit;
      logic                  last_of_run;
   } result_type;

endpackage

// ----- rtl/utf8_to_utf16_decoder.sv -----
// utf8_to_utf16_decoder.sv
// utf-8 byte stream decoder to utf-16 units or code points
// depends on u8u16_pkg and utf8_to_utf16_decoder_macros.svh
//
// usage
// - req_ channel carries one utf-8 byte per item plus a last-byte flag
// - rsp_ channel returns code units; rsp_last_of_run marks the final result
//   of the byte that caused it (bytes may give zero, one or two results)
// - csr_ channel writes the mode registers (index 0 utf16_output, index 1
//   low_surrogate_first); csr_ready is always high, other indexes are ignored
// - a byte is decoded in the cycle it is accepted and its results enter a
//   four-entry result queue; rsp_ shows the registered head of that queue
// - one byte per cycle is taken while results drain; a surrogate pair gives
//   two results but comes from four input bytes, so the input never
//   stalls unless rsp_stall holds results back
// - req_stall rises when fewer than two queue entries are free, whatever
//   rsp_stall does; a stalled rsp_ item holds steady at the queue head
// - reset empties the queue, clears the decoder state and sets utf16_output
//   to 1 and low_surrogate_first to 0; a byte with last set also clears the
//   decoder state but not the registers
module utf8_to_utf16_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [u8u16_pkg::BYTE_WIDTH-1:0]      req_in_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [u8u16_pkg::CODE_WIDTH-1:0]      rsp_code_unit,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [u8u16_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [u8u16_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // mode registers
   logic utf16_ff;
   logic low_first_ff;

   // decoder state
   logic [u8u16_pkg::CODE_WIDTH-1:0] partial_ff, partial_in;
   logic [1:0]                       cont_ff, cont_in;
   logic [1:0]                       swallow_ff, swallow_in;
   u8u16_pkg::check_type             check_ff, check_in;

   // result queue
   u8u16_pkg::result_type                 queue_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [u8u16_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8u16_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8u16_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   // decode outputs
   logic                             req_fire;
   logic                             rsp_fire;
   logic                             emit;
   logic [u8u16_pkg::CODE_WIDTH-1:0] emit_value;
   logic                             do_cont;
   logic                             check_fail;
   logic                             is_cont_byte;
   logic                             split;
   logic [19:0]                      supp_offset;
   logic [u8u16_pkg::CODE_WIDTH-1:0] hi_surr, lo_surr;
   logic [1:0]                       push_count;
   u8u16_pkg::result_type            push0, push1;

   assign req_fire     = req_valid && !req_stall;
   assign rsp_fire     = rsp_valid && !rsp_stall;
   assign is_cont_byte = (req_in_byte[7:6] == 2'b10);

   // byte decode and next decoder state
   always_comb begin
      partial_in = partial_ff;
      cont_in    = cont_ff;
      swallow_in = swallow_ff;
      check_in   = check_ff;
      emit       = 1'b0;
      emit_value = u8u16_pkg::REPLACEMENT_CHAR;
      do_cont    = 1'b0;
      check_fail = 1'b0;

      if (swallow_ff != 2'd0) begin
         swallow_in = swallow_ff - 2'd1;
      end else if (check_ff != u8u16_pkg::CHK_NONE) begin
         check_in = u8u16_pkg::CHK_NONE;
         unique case (check_ff)
            u8u16_pkg::CHK_E0: check_fail = (req_in_byte >= 8'h80) && (req_in_byte <= 8'h9F);
            u8u16_pkg::CHK_ED: check_fail = (req_in_byte >= 8'hA0) && (req_in_byte <= 8'hBF);
            u8u16_pkg::CHK_F0: check_fail = (req_in_byte >= 8'h80) && (req_in_byte <= 8'h8F);
            u8u16_pkg::CHK_F4: check_fail = (req_in_byte >= 8'h90) && (req_in_byte <= 8'hBF);
            default:           check_fail = 1'b0;
         endcase
         if (check_fail) begin
            emit       = 1'b1;
            emit_value = u8u16_pkg::REPLACEMENT_CHAR;
            swallow_in = (check_ff == u8u16_pkg::CHK_E0 || check_ff == u8u16_pkg::CHK_ED)
                         ? 2'd1 : 2'd2;
            cont_in    = 2'd0;
            partial_in = '0;
         end else begin
            do_cont = 1'b1;
         end
      end else if (cont_ff != 2'd0) begin
         do_cont = 1'b1;
      end else begin
         // lead byte classes
         if (req_in_byte < 8'h80) begin
            emit       = 1'b1;
            emit_value = {13'd0, req_in_byte};
         end else if (req_in_byte < 8'hC0 || req_in_byte > 8'hF4) begin
            emit       = 1'b1;
            emit_value = u8u16_pkg::REPLACEMENT_CHAR;
         end else if (req_in_byte < 8'hC2) begin
            emit       = 1'b1;
            emit_value = u8u16_pkg::REPLACEMENT_CHAR;
            swallow_in = 2'd1;
         end else if (req_in_byte < 8'hE0) begin
            partial_in = {16'd0, req_in_byte[4:0]};
            cont_in    = 2'd1;
         end else if (req_in_byte < 8'hF0) begin
            partial_in = {17'd0, req_in_byte[3:0]};
            cont_in    = 2'd2;
            if (req_in_byte == 8'hE0) check_in = u8u16_pkg::CHK_E0;
            if (req_in_byte == 8'hED) check_in = u8u16_pkg::CHK_ED;
         end else begin
            partial_in = {18'd0, req_in_byte[2:0]};
            cont_in    = 2'd3;
            if (req_in_byte == 8'hF0) check_in = u8u16_pkg::CHK_F0;
            if (req_in_byte == 8'hF4) check_in = u8u16_pkg::CHK_F4;
         end
      end

      // continuation byte
      if (do_cont) begin
         if (!is_cont_byte) begin
            emit       = 1'b1;
            emit_value = u8u16_pkg::REPLACEMENT_CHAR;
            swallow_in = cont_ff - 2'd1;
            cont_in    = 2'd0;
            partial_in = '0;
         end else begin
            partial_in = {partial_ff[14:0], req_in_byte[5:0]};
            cont_in    = cont_ff - 2'd1;
            if (cont_in == 2'd0) begin
               emit       = 1'b1;
               emit_value = partial_in;
               partial_in = '0;
            end
         end
      end

      // end of stream: flag a cut-off sequence, then clear
      if (req_last_byte) begin
         if (cont_in != 2'd0 && !emit) begin
            emit       = 1'b1;
            emit_value = u8u16_pkg::REPLACEMENT_CHAR;
         end
         partial_in = '0;
         cont_in    = 2'd0;
         swallow_in = 2'd0;
         check_in   = u8u16_pkg::CHK_NONE;
      end
   end

   // surrogate split
   always_comb begin
      supp_offset = 20'(emit_value - u8u16_pkg::SUPP_PLANE_BASE);
      split       = utf16_ff && (emit_value[20:16] != 5'd0);
      hi_surr     = u8u16_pkg::HI_SURR_BASE | {11'd0, supp_offset[19:10]};
      lo_surr     = u8u16_pkg::LO_SURR_BASE | {11'd0, supp_offset[9:0]};
      push0.code_unit   = split ? (low_first_ff ? lo_surr : hi_surr) : emit_value;
      push0.last_of_run = !split;
      push1.code_unit   = low_first_ff ? hi_surr : lo_surr;
      push1.last_of_run = 1'b1;
      push_count  = (req_fire && emit) ? (split ? 2'd2 : 2'd1) : 2'd0;
   end

   // queue pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + u8u16_pkg::QUEUE_PTR_WIDTH'(push_count);
      rd_ptr_in = rd_ptr_ff + u8u16_pkg::QUEUE_PTR_WIDTH'(rsp_fire);
      count_in  = count_ff + u8u16_pkg::QUEUE_CNT_WIDTH'(push_count)
                  - u8u16_pkg::QUEUE_CNT_WIDTH'(rsp_fire);
   end

   assign req_stall       = (count_ff > u8u16_pkg::QUEUE_CNT_WIDTH'(u8u16_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid       = (count_ff != '0);
   assign rsp_code_unit   = queue_ff[rd_ptr_ff].code_unit;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;
   assign csr_ready       = 1'b1;

   // control state and mode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         utf16_ff     <= 1'b1;
         low_first_ff <= 1'b0;
         partial_ff   <= '0;
         cont_ff      <= 2'd0;
         swallow_ff   <= 2'd0;
         check_ff     <= u8u16_pkg::CHK_NONE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               u8u16_pkg::CSR_UTF16_OUTPUT:        utf16_ff     <= csr_write_data[0];
               u8u16_pkg::CSR_LOW_SURROGATE_FIRST: low_first_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         if (req_fire) begin
            partial_ff <= partial_in;
            cont_ff    <= cont_in;
            swallow_ff <= swallow_in;
            check_ff   <= check_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + u8u16_pkg::QUEUE_PTR_WIDTH'(1)] <= push1;
      end
   end

`include "utf8_to_utf16_decoder_macros.svh"

   `U8U16_ASSERT_NOW(a_swallow_excl, swallow_ff != 2'd0, cont_ff == 2'd0,
      "swallow with open sequence")
   `U8U16_ASSERT_NOW(a_check_needs_seq, check_ff != u8u16_pkg::CHK_NONE, cont_ff >= 2'd2,
      "range check without multi-byte sequence")
   `U8U16_ASSERT_NEXT(a_last_clears, req_fire && req_last_byte,
      partial_ff == '0 && cont_ff == 2'd0 && swallow_ff == 2'd0
         && check_ff == u8u16_pkg::CHK_NONE,
      "state not cleared after last byte")
   `U8U16_ASSERT_NOW(a_pair_queued, rsp_valid && !rsp_last_of_run,
      count_ff >= u8u16_pkg::QUEUE_CNT_WIDTH'(2),
      "first surrogate without its partner queued")

endmodule

// ----- dv/utf8_decode_checker.sv -----
// utf8_decode_checker.sv
// watches the byte, code unit and register channels of the utf-8 decoder,
// predicts the code units of each accepted byte and compares them; uses u8u16_pkg
module utf8_decode_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [u8u16_pkg::BYTE_WIDTH-1:0]      req_in_byte,
   input  logic                                 req_last_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [u8u16_pkg::CODE_WIDTH-1:0]      rsp_code_unit,
   input  logic                                 rsp_last_of_run,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [u8u16_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [u8u16_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                                   fail_count,
   output int                                   pending_count
);
   import u8u16_pkg::*;

   // mode registers as the decoder should hold them
   logic utf16_mode;
   logic low_first;

   // decoder state copy
   logic [CODE_WIDTH-1:0] partial_cp;
   logic [1:0]            cont_left;
   logic [1:0]            swallow_left;
   check_type             pending_check;

   // code units caused by the byte being decoded
   result_type byte_units [2];
   int         unit_count;

   // code units still to come from the decoder
   result_type expected_units [$];
   result_type want;
   int         error_total = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // queue one value, split into a surrogate pair above the bmp in utf-16 mode
   function automatic void put_code(input logic [CODE_WIDTH-1:0] value);
      logic [19:0]           offset;
      logic [CODE_WIDTH-1:0] high_unit;
      logic [CODE_WIDTH-1:0] low_unit;
      if (utf16_mode && value > 21'h00FFFF) begin
         if (unit_count == 0) begin
            offset    = 20'(value - SUPP_PLANE_BASE);
            high_unit = HI_SURR_BASE | {11'd0, offset[19:10]};
            low_unit  = LO_SURR_BASE | {11'd0, offset[9:0]};
            byte_units[0] = '{code_unit: low_first ? low_unit : high_unit, last_of_run: 1'b0};
            byte_units[1] = '{code_unit: low_first ? high_unit : low_unit, last_of_run: 1'b0};
            unit_count = 2;
         end
      end else if (unit_count < 2) begin
         byte_units[unit_count] = '{code_unit: value, last_of_run: 1'b0};
         unit_count = unit_count + 1;
      end
   endfunction

   // continuation byte of an open sequence
   function automatic void take_continuation(input logic [7:0] value);
      if (value[7:6] != 2'b10) begin
         put_code(REPLACEMENT_CHAR);
         swallow_left = cont_left - 2'd1;
         cont_left    = 2'd0;
         partial_cp   = '0;
      end else begin
         partial_cp = {partial_cp[14:0], value[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            put_code(partial_cp);
            partial_cp = '0;
         end
      end
   endfunction

   // byte outside any sequence
   function automatic void take_lead(input logic [7:0] value);
      if (value < 8'h80) begin
         put_code({13'd0, value});
      end else if (value < 8'hC0 || value > 8'hF4) begin
         put_code(REPLACEMENT_CHAR);
      end else if (value < 8'hC2) begin
         // overlong two-byte lead drops the byte after it
         swallow_left = 2'd1;
         put_code(REPLACEMENT_CHAR);
      end else if (value < 8'hE0) begin
         partial_cp = {16'd0, value[4:0]};
         cont_left  = 2'd1;
      end else if (value < 8'hF0) begin
         partial_cp = {17'd0, value[3:0]};
         cont_left  = 2'd2;
         if (value == 8'hE0) pending_check = CHK_E0;
         if (value == 8'hED) pending_check = CHK_ED;
      end else begin
         partial_cp = {18'd0, value[2:0]};
         cont_left  = 2'd3;
         if (value == 8'hF0) pending_check = CHK_F0;
         if (value == 8'hF4) pending_check = CHK_F4;
      end
   endfunction

   function automatic void clear_stream();
      partial_cp    = '0;
      cont_left     = 2'd0;
      swallow_left  = 2'd0;
      pending_check = CHK_NONE;
   endfunction

   // decode one accepted byte and queue its code units
   function automatic void decode_byte(input logic [7:0] value, input logic last);
      check_type kind;
      logic      fail;
      unit_count = 0;
      if (swallow_left != 2'd0) begin
         swallow_left = swallow_left - 2'd1;
      end else if (pending_check != CHK_NONE) begin
         // range check of the first continuation after e0, ed, f0 and f4
         kind          = pending_check;
         pending_check = CHK_NONE;
         case (kind)
            CHK_E0:  fail = (value >= 8'h80 && value <= 8'h9F);
            CHK_ED:  fail = (value >= 8'hA0 && value <= 8'hBF);
            CHK_F0:  fail = (value >= 8'h80 && value <= 8'h8F);
            default: fail = (value >= 8'h90 && value <= 8'hBF);
         endcase
         if (fail) begin
            put_code(REPLACEMENT_CHAR);
            swallow_left = (kind == CHK_E0 || kind == CHK_ED) ? 2'd1 : 2'd2;
            cont_left    = 2'd0;
            partial_cp   = '0;
         end else begin
            take_continuation(value);
         end
      end else if (cont_left != 2'd0) begin
         take_continuation(value);
      end else begin
         take_lead(value);
      end
      // sequence cut off by the end of the stream
      if (last) begin
         if (cont_left != 2'd0 && unit_count == 0) put_code(REPLACEMENT_CHAR);
         clear_stream();
      end
      if (unit_count > 0) byte_units[unit_count-1].last_of_run = 1'b1;
      for (int i = 0; i < unit_count; i++) expected_units.push_back(byte_units[i]);
   endfunction

   // sample all channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         utf16_mode = 1'b1;
         low_first  = 1'b0;
         clear_stream();
         expected_units.delete();
      end else begin
         // compare a delivered code unit with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected code unit: expected none, actual %h last %b",
                        $time, rsp_code_unit, rsp_last_of_run);
               error_total = error_total + 1;
            end else begin
               want = expected_units.pop_front();
               if (rsp_code_unit !== want.code_unit) begin
                  $display("%0t: code_unit mismatch: expected %h, actual %h",
                           $time, want.code_unit, rsp_code_unit);
                  error_total = error_total + 1;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run mismatch: expected %b, actual %b",
                           $time, want.last_of_run, rsp_last_of_run);
                  error_total = error_total + 1;
               end
            end
         end
         // register writes, other indexes are ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UTF16_OUTPUT:        utf16_mode = csr_write_data[0];
               CSR_LOW_SURROGATE_FIRST: low_first  = csr_write_data[0];
               default: ;
            endcase
         end
         // accepted byte item
         if (req_valid && !req_stall) decode_byte(req_in_byte, req_last_byte);
      end
      fail_count    <= error_total;
      pending_count <= expected_units.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// tb_top.sv
// stimulus for the utf-8 decoder: directed and random byte streams over
// several register settings; depends on u8u16_pkg, utf8_to_utf16_decoder and utf8_decode_checker
module tb_top;
   import u8u16_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PER_PHASE = 240;

   // register indexes with no register behind them
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HIGH = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [BYTE_WIDTH-1:0]      req_in_byte = '0;
   logic                       req_last_byte = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [CODE_WIDTH-1:0]      rsp_code_unit;
   logic                       rsp_last_of_run;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   int   fail_count;
   int   pending_count;
   int   idle_pct = 32;
   int   stall_pct = 32;
   int   bytes_sent = 0;
   int   quiet_cycles = 0;
   logic hold_off_request = 1'b0;

   utf8_to_utf16_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   utf8_decode_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // code unit receiver: random stalls, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request <= 1'b0;
            rsp_stall <= 1'b1;
            for (int i = 0; i < HOLD_OFF_CYCLES; i++) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // cycles without any accepted item end the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // offer one byte item, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent = bytes_sent + 1;
   endtask

   // occasional end of stream, often in the middle of a sequence
   function automatic logic stream_end();
      return ($urandom_range(0, 63) == 0);
   endfunction

   // mostly well-formed characters with random content, some noise
   task automatic send_random_char();
      int         kind;
      int         extra;
      logic [7:0] lead;
      logic [7:0] first_cont;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         send_byte(8'($urandom_range(0, 8'h7F)), stream_end());
      end else if (kind < 45) begin
         send_byte(8'($urandom_range(8'hC2, 8'hDF)), stream_end());
         send_byte(8'($urandom_range(8'h80, 8'hBF)), stream_end());
      end else if (kind < 85) begin
         // three- or four-byte sequence with an in-range first continuation
         if (kind < 65) lead = 8'($urandom_range(8'hE0, 8'hEF));
         else lead = 8'($urandom_range(8'hF0, 8'hF4));
         case (lead)
            8'hE0:   first_cont = 8'($urandom_range(8'hA0, 8'hBF));
            8'hED:   first_cont = 8'($urandom_range(8'h80, 8'h9F));
            8'hF0:   first_cont = 8'($urandom_range(8'h90, 8'hBF));
            8'hF4:   first_cont = 8'($urandom_range(8'h80, 8'h8F));
            default: first_cont = 8'($urandom_range(8'h80, 8'hBF));
         endcase
         send_byte(lead, stream_end());
         send_byte(first_cont, stream_end());
         send_byte(8'($urandom_range(8'h80, 8'hBF)), stream_end());
         if (lead >= 8'hF0) send_byte(8'($urandom_range(8'h80, 8'hBF)), stream_end());
      end else if (kind < 93) begin
         send_byte(8'($urandom_range(0, 255)), stream_end());
      end else begin
         // broken sequence: any lead followed by arbitrary bytes
         send_byte(8'($urandom_range(8'hC0, 8'hFF)), stream_end());
         extra = $urandom_range(1, 3);
         for (int i = 0; i < extra; i++) send_byte(8'($urandom_range(0, 255)), stream_end());
      end
   endtask

   // random stream that ends with a closing byte, then the bus goes quiet
   task automatic run_random(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) send_random_char();
      send_byte(8'($urandom_range(0, 8'h7F)), 1'b1);
      req_valid <= 1'b0;
   endtask

   // wait until every predicted code unit has come out
   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input logic value);
      csr_valid      <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bytes at the reset settings
      send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h80, 1'b0);
      // overlong lead swallows the next byte
      send_byte(8'hC0, 1'b0); send_byte(8'h41, 1'b0);
      send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
      // failed first-continuation checks
      send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
      // first supplementary code point, then an out-of-range f4 sequence and an invalid byte
      send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      // bad continuation, rest of the sequence swallowed
      send_byte(8'hE1, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0);
      // sequence cut off by the last byte
      send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
      run_random(RANDOM_PER_PHASE);
      drain();

      // low surrogate first, receiver holds off so the input backs up
      write_reg(CSR_LOW_SURROGATE_FIRST, 1'b1);
      write_reg(CSR_UNMAPPED_LOW, 1'b0);
      hold_off_request <= 1'b1;
      run_random(RANDOM_PER_PHASE);
      drain();

      // whole code points, no idling on either side
      write_reg(CSR_UTF16_OUTPUT, 1'b0);
      write_reg(CSR_LOW_SURROGATE_FIRST, 1'b0);
      write_reg(CSR_UNMAPPED_HIGH, 1'b1);
      idle_pct  = 0;
      stall_pct = 0;
      run_random(RANDOM_PER_PHASE);
      drain();
      idle_pct  = 32;
      stall_pct = 32;

      // whole code points with the order bit set
      write_reg(CSR_LOW_SURROGATE_FIRST, 1'b1);
      run_random(RANDOM_PER_PHASE);
      drain();

      // random settings
      write_reg(CSR_UTF16_OUTPUT, 1'($urandom_range(0, 1)));
      write_reg(CSR_LOW_SURROGATE_FIRST, 1'($urandom_range(0, 1)));
      run_random(RANDOM_PER_PHASE);
      drain();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
